@@ hdl/signed_restoring_divider_top_assert.svh @@
// assertion macros shared by the divider checker
`ifndef SIGNED_RESTORING_DIVIDER_TOP_ASSERT_SVH
`define SIGNED_RESTORING_DIVIDER_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define SRD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define SRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/srd_pkg.sv @@
// package for the signed restoring divider: defaults and fsm state type
`timescale 1ns / 1ps
package srd_pkg;

    localparam int SRD_WIDTH_DEF = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIX
    } srd_state_t;

endpackage

@@ hdl/signed_restoring_divider_top.sv @@
// signed restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
// an accepted item runs through the shift-subtract steps in ST_DIV, then the sign
// fix-up in ST_FIX; a zero divisor skips the shift-subtract steps and goes to ST_FIX
// a new item is taken only in ST_IDLE, after the previous item has loaded its result;
// ST_FIX waits while the output register still holds a result that is not taken
// the result sits in an output register; a new item is taken while it waits
// reset (rst_n low, asynchronous) empties the pipeline and drops any pending result
module signed_restoring_divider_top #(
    parameter int WIDTH = srd_pkg::SRD_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [WIDTH-1:0] dividend,
    input  logic signed [WIDTH-1:0] divisor,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [WIDTH-1:0] quotient,
    output logic signed [WIDTH-1:0] remainder,
    output logic                    divide_by_zero
);
    import srd_pkg::*;

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    // control state
    srd_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;

    // datapath: dq_reg shifts dividend bits out at the top and quotient bits in at the bottom
    logic [WIDTH-1:0]   dq_reg, dq_next;
    logic [WIDTH-1:0]   dvs_reg, dvs_next;
    logic [WIDTH-1:0]   part_reg, part_next;
    logic               sa_reg, sa_next;
    logic               sb_reg, sb_next;
    logic               dz_reg, dz_next;
    logic [WIDTH-1:0]   quo_out_reg, quo_out_next;
    logic [WIDTH-1:0]   rem_out_reg, rem_out_next;
    logic               dz_out_reg, dz_out_next;

    // fsm outputs
    logic               accept;
    logic               do_step;
    logic               do_load;
    logic               out_free;

    // combinational helpers
    logic [WIDTH-1:0]   a_u, b_u, a_mag, b_mag;
    logic               b_zero;
    logic [WIDTH:0]     trial, diff;
    logic               q_bit;
    logic [WIDTH-1:0]   quo_fix, rem_fix;

    assign out_free = !out_valid_reg || out_ready;

    // input magnitudes
    assign a_u    = dividend;
    assign b_u    = divisor;
    assign a_mag  = a_u[WIDTH-1] ? (~a_u + {{(WIDTH-1){1'b0}}, 1'b1}) : a_u;
    assign b_mag  = b_u[WIDTH-1] ? (~b_u + {{(WIDTH-1){1'b0}}, 1'b1}) : b_u;
    assign b_zero = (b_u == '0);

    // one restoring step: bring in the next dividend bit, try the subtraction
    assign trial = {part_reg, dq_reg[WIDTH-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign q_bit = !diff[WIDTH];

    // sign fix-up; on a zero divisor dq_reg still holds the raw dividend
    always_comb
    begin
        if (dz_reg)
        begin
            quo_fix = '1;
            rem_fix = dq_reg;
        end
        else
        begin
            quo_fix = (sa_reg ^ sb_reg) ? (~dq_reg + {{(WIDTH-1){1'b0}}, 1'b1}) : dq_reg;
            rem_fix = sa_reg ? (~part_reg + {{(WIDTH-1){1'b0}}, 1'b1}) : part_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = b_zero ? ST_FIX : ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = ST_FIX;
            end
            ST_FIX:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb
    begin
        in_ready = 1'b0;
        do_step  = 1'b0;
        do_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_DIV:  do_step  = 1'b1;
            ST_FIX:  do_load  = out_free;
            default: in_ready = 1'b0;
        endcase
    end

    assign accept = in_valid && in_ready;

    // datapath next values
    always_comb
    begin
        cnt_next     = cnt_reg;
        dq_next      = dq_reg;
        dvs_next     = dvs_reg;
        part_next    = part_reg;
        sa_next      = sa_reg;
        sb_next      = sb_reg;
        dz_next      = dz_reg;
        quo_out_next = quo_out_reg;
        rem_out_next = rem_out_reg;
        dz_out_next  = dz_out_reg;

        if (accept)
        begin
            cnt_next  = CNT_W'(WIDTH - 1);
            dq_next   = b_zero ? a_u : a_mag;
            dvs_next  = b_mag;
            part_next = '0;
            sa_next   = a_u[WIDTH-1];
            sb_next   = b_u[WIDTH-1];
            dz_next   = b_zero;
        end
        else if (do_step)
        begin
            cnt_next  = cnt_reg - {{(CNT_W-1){1'b0}}, 1'b1};
            dq_next   = {dq_reg[WIDTH-2:0], q_bit};
            part_next = q_bit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
        end

        if (do_load)
        begin
            quo_out_next = quo_fix;
            rem_out_next = rem_fix;
            dz_out_next  = dz_reg;
        end
    end

    // result register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (do_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        dq_reg      <= dq_next;
        dvs_reg     <= dvs_next;
        part_reg    <= part_next;
        sa_reg      <= sa_next;
        sb_reg      <= sb_next;
        dz_reg      <= dz_next;
        quo_out_reg <= quo_out_next;
        rem_out_reg <= rem_out_next;
        dz_out_reg  <= dz_out_next;
    end

    assign out_valid      = out_valid_reg;
    assign quotient       = quo_out_reg;
    assign remainder      = rem_out_reg;
    assign divide_by_zero = dz_out_reg;

endmodule

@@ hdl/srd_checker.sv @@
// port-level checker for the signed restoring divider and its bind
`timescale 1ns / 1ps
`include "signed_restoring_divider_top_assert.svh"
module srd_checker #(
    parameter int WIDTH = srd_pkg::SRD_WIDTH_DEF
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [WIDTH-1:0] quotient,
    input logic signed [WIDTH-1:0] remainder,
    input logic                    divide_by_zero
);
    import srd_pkg::*;

    // a waiting result holds
    `SRD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(quotient) && $stable(remainder) && $stable(divide_by_zero), "result changed while stalled")

    // one item at a time
    `SRD_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "input taken while busy")

    // zero divisor gives all-ones quotient
    `SRD_ASSERT_NOW(a_dz_quo, out_valid && divide_by_zero, quotient == {WIDTH{1'b1}}, "bad quotient on zero divisor")

    // no result appears right after an accept
    `SRD_ASSERT_NEXT(a_no_early, in_valid && in_ready && !out_valid, !out_valid, "result too early")

endmodule

bind signed_restoring_divider_top srd_checker #(.WIDTH(WIDTH)) u_srd_checker (.*);

@@ sim/divider_checker.sv @@
// checker for the signed divider: predicts quotient and remainder and compares each result
`timescale 1ns / 1ps
module divider_checker #(
    parameter int W = srd_pkg::SRD_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_ready,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    input  logic         out_valid,
    input  logic         out_ready,
    input  logic [W-1:0] quotient,
    input  logic [W-1:0] remainder,
    input  logic         divide_by_zero,
    output int           mismatches,
    output int           pending,
    output int           checked
);

    typedef struct packed {
        logic [W-1:0] quo;
        logic [W-1:0] rem;
        logic         dbz;
    } quot_rem_t;

    typedef struct {
        logic [W-1:0] num;
        logic [W-1:0] den;
        quot_rem_t    res;
    } awaited_div_t;

    awaited_div_t awaited_q[$];
    int           fail_count = 0;
    int           check_count = 0;

    // restoring division on magnitudes, then sign fix-up
    function automatic quot_rem_t divide_signed(input logic [W-1:0] num, input logic [W-1:0] den);
        logic [W-1:0] num_mag;
        logic [W-1:0] den_mag;
        logic [W-1:0] quo;
        logic [W:0]   part;
        quot_rem_t    r;
        if (den == '0)
        begin
            r.quo = '1;
            r.rem = num;
            r.dbz = 1'b1;
            return r;
        end
        num_mag = num[W-1] ? -num : num;
        den_mag = den[W-1] ? -den : den;
        part = '0;
        quo = '0;
        for (int i = W - 1; i >= 0; i--)
        begin
            part = {part[W-1:0], num_mag[i]};
            if (part >= {1'b0, den_mag})
            begin
                part = part - {1'b0, den_mag};
                quo[i] = 1'b1;
            end
        end
        r.quo = (num[W-1] ^ den[W-1]) ? -quo : quo;
        r.rem = num[W-1] ? -part[W-1:0] : part[W-1:0];
        r.dbz = 1'b0;
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t ns: %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        awaited_div_t head;
        quot_rem_t    got;
        string        bad;
        if (!rst_n)
        begin
            awaited_q.delete();
        end
        else
        begin
            // results first, so an item taken this cycle can never match itself
            if (out_valid && out_ready)
            begin
                got = '{quotient, remainder, divide_by_zero};
                if (awaited_q.size() == 0)
                begin
                    note_failure($sformatf("unexpected result q=%0d r=%0d dbz=%0b",
                        $signed(got.quo), $signed(got.rem), got.dbz));
                end
                else
                begin
                    head = awaited_q.pop_front();
                    check_count++;
                    bad = "";
                    if (got.quo !== head.res.quo)
                        bad = {bad, " quotient"};
                    if (got.rem !== head.res.rem)
                        bad = {bad, " remainder"};
                    if (got.dbz !== head.res.dbz)
                        bad = {bad, " divide_by_zero"};
                    if (bad != "")
                        note_failure($sformatf(
                            "%0d / %0d wrong%s: expected q=%0d r=%0d dbz=%0b, got q=%0d r=%0d dbz=%0b",
                            $signed(head.num), $signed(head.den), bad,
                            $signed(head.res.quo), $signed(head.res.rem), head.res.dbz,
                            $signed(got.quo), $signed(got.rem), got.dbz));
                end
            end
            if (in_valid && in_ready)
                awaited_q.push_back('{dividend, divisor, divide_signed(dividend, divisor)});
        end
        pending <= awaited_q.size();
        mismatches <= fail_count;
        checked <= check_count;
    end

endmodule

@@ sim/testbench.sv @@
// top of the divider testbench: clock, reset, stimulus, receiver stalls and verdict
`timescale 1ns / 1ps
module testbench;

    localparam int W = srd_pkg::SRD_WIDTH_DEF;
    localparam int DIRECTED_ITEMS = 25;
    localparam int RANDOM_ITEMS = 1225;
    localparam int HOLD_CYCLES = 80;
    localparam int HOLD_AFTER = 300;

    localparam logic [W-1:0] MOST_NEG = {1'b1, {(W - 1){1'b0}}};
    localparam logic [W-1:0] MOST_POS = {1'b0, {(W - 1){1'b1}}};

    logic         clk;
    logic         rst_n;
    logic         in_valid;
    logic         in_ready;
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
    logic         out_valid;
    logic         out_ready;
    logic [W-1:0] quotient;
    logic [W-1:0] remainder;
    logic         divide_by_zero;

    int mismatches;
    int pending;
    int checked;

    // sender bookkeeping
    int sent = 0;
    int zero_div_sent = 0;
    int burst_left = 1;

    // receiver hold-off, visible to the sender so it keeps offering meanwhile
    bit rx_hold = 1'b0;
    bit hold_done = 1'b0;
    int rx_cycle = 0;

    // directed operands: extremes, zero divisor, overflow, every sign pairing
    int dir_num [DIRECTED_ITEMS] = '{0, 127, -128, -128, -128, 127, -128, 127, -128, 127,
                                     -1, 1, -7, 7, -7, 7, 0, 0, 5, -5,
                                     1, -127, -128, 100, -100};
    int dir_den [DIRECTED_ITEMS] = '{0, 0, 0, -1, 1, -1, 127, -128, -128, 127,
                                     1, -1, 2, -2, -2, 2, 5, -128, 7, 7,
                                     -128, -128, 2, -3, 3};

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    signed_restoring_divider_top #(
        .WIDTH(W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .dividend      (dividend),
        .divisor       (divisor),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .quotient      (quotient),
        .remainder     (remainder),
        .divide_by_zero(divide_by_zero)
    );

    divider_checker #(
        .W(W)
    ) div_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .dividend      (dividend),
        .divisor       (divisor),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .quotient      (quotient),
        .remainder     (remainder),
        .divide_by_zero(divide_by_zero),
        .mismatches    (mismatches),
        .pending       (pending),
        .checked       (checked)
    );

    // one of the values that sit at the corners of the signed range
    function automatic logic [W-1:0] extreme_value();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return {{(W - 1){1'b0}}, 1'b1};
            2: return '1;
            3: return MOST_NEG;
            default: return MOST_POS;
        endcase
    endfunction

    // present one item and hold it until accepted, then maybe end the burst
    task automatic offer(input logic [W-1:0] a, input logic [W-1:0] b);
        int gap;
        in_valid <= 1'b1;
        dividend <= a;
        divisor <= b;
        do @(posedge clk); while (!in_ready);
        sent++;
        if (b == '0)
            zero_div_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            // no gaps while the receiver holds off, so the block backs up
            if (rx_hold)
                gap = 0;
            else if ($urandom_range(0, 9) == 0)
                gap = $urandom_range(20, 40);
            else
                gap = $urandom_range(0, 12);
            if ($urandom_range(0, 4) == 0)
                burst_left = $urandom_range(30, 60);
            else
                burst_left = $urandom_range(1, 12);
            // a zero gap keeps valid high, so it is never lowered and raised in one step
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // stop offering until every outstanding item has produced its result
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // receiver: cycles through ready patterns, with one long hold-off
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (!hold_done && sent >= HOLD_AFTER)
            begin
                rx_hold = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold = 1'b0;
                hold_done = 1'b1;
            end
            else
            begin
                case ((rx_cycle / 500) % 4)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 99) < 60);
                    2: out_ready <= ((rx_cycle % 7) < 4);
                    default: out_ready <= ($urandom_range(0, 99) < 20);
                endcase
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        logic [W-1:0] a;
        logic [W-1:0] b;
        int           kind;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        dividend <= '0;
        divisor <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corner cases
        for (int i = 0; i < DIRECTED_ITEMS; i++)
            offer(W'(dir_num[i]), W'(dir_den[i]));
        wait_for_results();

        // random operands, biased toward small and extreme divisors and extreme dividends
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            kind = $urandom_range(0, 99);
            a = W'($urandom);
            b = W'($urandom);
            if (kind < 15)
                b = W'($urandom_range(0, 8) - 4);
            else if (kind < 25)
                b = extreme_value();
            else if (kind < 35)
                a = extreme_value();
            else if (kind < 40)
            begin
                a = extreme_value();
                b = extreme_value();
            end
            offer(a, b);
            // mid-run pause until the block has drained
            if (i == RANDOM_ITEMS / 2)
                wait_for_results();
        end
        wait_for_results();

        // allow for anything still in flight past the block's latency
        repeat (40) @(posedge clk);

        $display("divided %0d items (%0d directed, %0d by zero), %0d results checked",
            sent, DIRECTED_ITEMS, zero_div_sent, checked);
        $display("receiver ran through four ready patterns and one %0d-cycle hold-off",
            HOLD_CYCLES);
        if (mismatches == 0 && pending == 0)
            $display("signed_restoring_divider_top regression: pass");
        else
            $display("signed_restoring_divider_top regression: fail");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #1_000_000;
        $display("signed_restoring_divider_top regression: fail");
        $finish;
    end

endmodule
